// File: rtl/pes_pkg.sv
// Package for the periodic event scheduler.
// Holds item types, entry layout, status and operation codes and scan control.
// No dependencies.
package pes_pkg;

  localparam int unsigned TimeW   = 48;
  localparam int unsigned IdW     = 16;
  localparam int unsigned PeriodW = 16;

  typedef enum logic {
    OP_REGISTER = 1'b0,
    OP_EMIT     = 1'b1
  } op_e;

  typedef enum logic [2:0] {
    ST_EMITTED    = 3'd0,
    ST_REGISTERED = 3'd1,
    ST_EMPTY      = 3'd2,
    ST_FULL       = 3'd3,
    ST_OVERFLOW   = 3'd4
  } status_e;

  typedef struct packed {
    op_e                  operation;
    logic [IdW-1:0]       entry_id;
    logic [PeriodW-1:0]   period;
  } in_t;

  typedef struct packed {
    status_e              status;
    logic [IdW-1:0]       emitted_id;
    logic [TimeW-1:0]     emitted_time;
  } out_t;

  // One stored table entry.
  typedef struct packed {
    logic [TimeW-1:0]     due;
    logic [IdW-1:0]       id;
    logic [PeriodW-1:0]   period;
  } entry_t;

  // Qualifies the candidate entry presented to the compare unit.
  typedef struct packed {
    logic vld;
    logic first;
  } scan_ctl_t;

endpackage

// File: rtl/pes_table.sv
// Entry table of the periodic event scheduler: one write port, one read port.
// Read data is registered. Depends on pes_pkg.
module pes_table #(
  parameter int unsigned Depth = 64,
  parameter int unsigned AddrW = 6
) (
  input  logic                clk_i,
  input  logic                we_i,
  input  logic [AddrW-1:0]    waddr_i,
  input  pes_pkg::entry_t     wdata_i,
  input  logic                re_i,
  input  logic [AddrW-1:0]    raddr_i,
  output pes_pkg::entry_t     rdata_o
);

  pes_pkg::entry_t mem_q [Depth];
  pes_pkg::entry_t rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// File: rtl/pes_cmp.sv
// Shared compare unit: keeps the earliest entry seen during a table scan.
// Order is due time, then id, then period. Depends on pes_pkg.
module pes_cmp #(
  parameter int unsigned AddrW = 6
) (
  input  logic                clk_i,
  input  pes_pkg::scan_ctl_t  ctl_i,
  input  logic [AddrW-1:0]    cand_idx_i,
  input  pes_pkg::entry_t     cand_i,
  output pes_pkg::entry_t     best_o,
  output logic [AddrW-1:0]    best_idx_o
);

  pes_pkg::entry_t  best_q, best_d;
  logic [AddrW-1:0] best_idx_q, best_idx_d;
  logic             cand_earlier;

  // A fully identical candidate does not replace the current one, so the
  // lowest table position wins.
  always_comb begin
    if (cand_i.due != best_q.due) begin
      cand_earlier = cand_i.due < best_q.due;
    end else if (cand_i.id != best_q.id) begin
      cand_earlier = cand_i.id < best_q.id;
    end else begin
      cand_earlier = cand_i.period < best_q.period;
    end
  end

  always_comb begin
    best_d     = best_q;
    best_idx_d = best_idx_q;
    if (ctl_i.vld && (ctl_i.first || cand_earlier)) begin
      best_d     = cand_i;
      best_idx_d = cand_idx_i;
    end
  end

  always_ff @(posedge clk_i) begin
    best_q     <= best_d;
    best_idx_q <= best_idx_d;
  end

  assign best_o     = best_q;
  assign best_idx_o = best_idx_q;

endmodule

// File: rtl/periodic_event_scheduler_core.sv
// Periodic event scheduler, top level: sequencer, output register and the
// table and compare units. Depends on pes_pkg, pes_table and pes_cmp.
//
// Input channel in_valid_i/in_ready_o carries one in_t item: a register
// operation appends an entry (first due time equals its period), an emit
// operation fires the entry with the smallest due time (ties by smaller id,
// then smaller period) and advances its due time by its period unless the sum
// overflows (status ST_OVERFLOW). Every item gives exactly one out_t result
// on out_valid_o/out_ready_i. A register item or an emit on an empty table
// needs no scan. An emit on a non-empty table has the single compare unit
// read one table entry per cycle through the table's read port; after a
// drain state, the update state adds the period and writes the entry back.
// One item is in work at a time; in_ready_o is high only while the sequencer
// is idle, so an item can be accepted while the previous result still waits
// in the output register. A stalled receiver holds that result and stops the
// sequencer before it would overwrite it.
// Reset clears the entry count and all control state; the table contents
// need no clearing because only entries below the count are ever read.
module periodic_event_scheduler_core #(
  parameter int unsigned MAX_ENTRIES = 64
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           in_valid_i,
  output logic           in_ready_o,
  input  pes_pkg::in_t   in_data_i,
  output logic           out_valid_o,
  input  logic           out_ready_i,
  output pes_pkg::out_t  out_data_o
);

  localparam int unsigned AddrW  = $clog2(MAX_ENTRIES);
  localparam int unsigned CountW = $clog2(MAX_ENTRIES + 1);

  typedef enum logic [4:0] {
    S_IDLE   = 5'b00001,
    S_SCAN   = 5'b00010,
    S_DRAIN  = 5'b00100,
    S_UPDATE = 5'b01000,
    S_RESP   = 5'b10000
  } state_e;

  state_e              state_q, state_d;
  logic [CountW-1:0]   count_q, count_d;
  logic [AddrW-1:0]    rd_idx_q, rd_idx_d;
  logic                rd_vld_q, rd_vld_d;
  logic                rd_first_q, rd_first_d;
  logic [AddrW-1:0]    rd_pos_q, rd_pos_d;
  logic                out_valid_q, out_valid_d;
  pes_pkg::out_t       out_q, out_d;
  pes_pkg::out_t       res_q, res_d;

  logic                we;
  logic [AddrW-1:0]    waddr;
  pes_pkg::entry_t     wdata;
  logic                re;
  pes_pkg::entry_t     rdata;
  pes_pkg::entry_t     best;
  logic [AddrW-1:0]    best_idx;
  pes_pkg::scan_ctl_t  scan_ctl;

  logic                accept;
  logic                full;
  logic                last;
  logic [pes_pkg::TimeW:0] sum;

  assign accept = in_valid_i && (state_q == S_IDLE);
  assign full   = count_q == CountW'(MAX_ENTRIES);
  assign last   = (CountW'(rd_idx_q) + CountW'(1)) == count_q;
  assign sum    = {1'b0, best.due} + (pes_pkg::TimeW + 1)'(best.period);

  assign scan_ctl.vld   = rd_vld_q;
  assign scan_ctl.first = rd_first_q;

  always_comb begin
    state_d     = state_q;
    count_d     = count_q;
    rd_idx_d    = rd_idx_q;
    rd_vld_d    = 1'b0;
    rd_first_d  = 1'b0;
    rd_pos_d    = rd_pos_q;
    out_valid_d = out_valid_q;
    out_d       = out_q;
    res_d       = res_q;
    we          = 1'b0;
    waddr       = best_idx;
    wdata       = best;
    re          = 1'b0;

    if (out_valid_q && out_ready_i) begin
      out_valid_d = 1'b0;
    end

    unique case (state_q)
      S_IDLE: begin
        if (accept) begin
          res_d.emitted_id   = '0;
          res_d.emitted_time = '0;
          if (in_data_i.operation == pes_pkg::OP_REGISTER) begin
            state_d = S_RESP;
            if (full) begin
              res_d.status = pes_pkg::ST_FULL;
            end else begin
              we           = 1'b1;
              waddr        = count_q[AddrW-1:0];
              wdata.due    = pes_pkg::TimeW'(in_data_i.period);
              wdata.id     = in_data_i.entry_id;
              wdata.period = in_data_i.period;
              count_d      = count_q + CountW'(1);
              res_d.status = pes_pkg::ST_REGISTERED;
            end
          end else if (count_q == '0) begin
            res_d.status = pes_pkg::ST_EMPTY;
            state_d      = S_RESP;
          end else begin
            rd_idx_d = '0;
            state_d  = S_SCAN;
          end
        end
      end
      S_SCAN: begin
        re         = 1'b1;
        rd_vld_d   = 1'b1;
        rd_first_d = rd_idx_q == '0;
        rd_pos_d   = rd_idx_q;
        if (last) begin
          state_d = S_DRAIN;
        end else begin
          rd_idx_d = rd_idx_q + AddrW'(1);
        end
      end
      S_DRAIN: begin
        // The last entry read is folded into the compare unit at this edge.
        state_d = S_UPDATE;
      end
      S_UPDATE: begin
        res_d.emitted_id   = best.id;
        res_d.emitted_time = best.due;
        if (sum[pes_pkg::TimeW]) begin
          res_d.status = pes_pkg::ST_OVERFLOW;
        end else begin
          we           = 1'b1;
          wdata.due    = sum[pes_pkg::TimeW-1:0];
          res_d.status = pes_pkg::ST_EMITTED;
        end
        state_d = S_RESP;
      end
      S_RESP: begin
        if (!out_valid_q || out_ready_i) begin
          out_valid_d = 1'b1;
          out_d       = res_q;
          state_d     = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      count_q     <= '0;
      rd_idx_q    <= '0;
      rd_vld_q    <= 1'b0;
      rd_first_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      count_q     <= count_d;
      rd_idx_q    <= rd_idx_d;
      rd_vld_q    <= rd_vld_d;
      rd_first_q  <= rd_first_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rd_pos_q <= rd_pos_d;
    out_q    <= out_d;
    res_q    <= res_d;
  end

  pes_table #(
    .Depth (MAX_ENTRIES),
    .AddrW (AddrW)
  ) u_table (
    .clk_i   (clk_i),
    .we_i    (we),
    .waddr_i (waddr),
    .wdata_i (wdata),
    .re_i    (re),
    .raddr_i (rd_idx_q),
    .rdata_o (rdata)
  );

  pes_cmp #(
    .AddrW (AddrW)
  ) u_cmp (
    .clk_i      (clk_i),
    .ctl_i      (scan_ctl),
    .cand_idx_i (rd_pos_q),
    .cand_i     (rdata),
    .best_o     (best),
    .best_idx_o (best_idx)
  );

  assign in_ready_o  = state_q == S_IDLE;
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

endmodule

// File: verif/tb.sv
// Self-checking testbench for periodic_event_scheduler_core.
// Depends on pes_pkg and the core; a built-in model predicts every result that no row
// fixes, and the run covers directed rows, random traffic, idle phases and back-pressure.
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned MaxEntries = 64;
  localparam int unsigned RandItems  = 1350;
  localparam int unsigned StallLimit = 4000;
  localparam int unsigned HoldCycles = 500;
  localparam int unsigned HoldAtItem = 700;

  typedef struct {
    pes_pkg::op_e                op;
    logic [pes_pkg::IdW-1:0]     id;
    logic [pes_pkg::PeriodW-1:0] period;
    bit                          known;
    pes_pkg::status_e            st;
    logic [pes_pkg::IdW-1:0]     oid;
    logic [pes_pkg::TimeW-1:0]   otime;
  } stim_row_t;

  // Opening rows: empty table, extreme fields and the tie-break order.
  stim_row_t head_rows [22] = '{
    '{pes_pkg::OP_EMIT, 16'h0000, 16'h0000, 1'b1, pes_pkg::ST_EMPTY, 16'h0000, 48'h0},
    '{pes_pkg::OP_REGISTER, 16'hFFFF, 16'hFFFF, 1'b1, pes_pkg::ST_REGISTERED, 16'h0000, 48'h0},
    '{pes_pkg::OP_EMIT, 16'hFFFF, 16'hFFFF, 1'b1, pes_pkg::ST_EMITTED, 16'hFFFF, 48'hFFFF},
    '{pes_pkg::OP_REGISTER, 16'h0000, 16'h0001, 1'b1, pes_pkg::ST_REGISTERED, 16'h0000, 48'h0},
    '{pes_pkg::OP_EMIT, 16'h0000, 16'h0000, 1'b1, pes_pkg::ST_EMITTED, 16'h0000, 48'h1},
    '{pes_pkg::OP_REGISTER, 16'h0000, 16'h0002, 1'b1, pes_pkg::ST_REGISTERED, 16'h0000, 48'h0},
    '{pes_pkg::OP_EMIT, 16'h0000, 16'h0000, 1'b0, pes_pkg::ST_EMITTED, 16'h0000, 48'h0},
    '{pes_pkg::OP_EMIT, 16'h0000, 16'h0000, 1'b0, pes_pkg::ST_EMITTED, 16'h0000, 48'h0},
    '{pes_pkg::OP_REGISTER, 16'h0003, 16'h0003, 1'b1, pes_pkg::ST_REGISTERED, 16'h0000, 48'h0},
    '{pes_pkg::OP_EMIT, 16'h0000, 16'h0000, 1'b0, pes_pkg::ST_EMITTED, 16'h0000, 48'h0},
    '{pes_pkg::OP_EMIT, 16'h0000, 16'h0000, 1'b0, pes_pkg::ST_EMITTED, 16'h0000, 48'h0},
    '{pes_pkg::OP_REGISTER, 16'h0009, 16'h0005, 1'b1, pes_pkg::ST_REGISTERED, 16'h0000, 48'h0},
    '{pes_pkg::OP_REGISTER, 16'h0009, 16'h0005, 1'b1, pes_pkg::ST_REGISTERED, 16'h0000, 48'h0},
    '{pes_pkg::OP_EMIT, 16'h0000, 16'h0000, 1'b0, pes_pkg::ST_EMITTED, 16'h0000, 48'h0},
    '{pes_pkg::OP_EMIT, 16'h0000, 16'h0000, 1'b0, pes_pkg::ST_EMITTED, 16'h0000, 48'h0},
    '{pes_pkg::OP_EMIT, 16'h0000, 16'h0000, 1'b0, pes_pkg::ST_EMITTED, 16'h0000, 48'h0},
    '{pes_pkg::OP_EMIT, 16'h0000, 16'h0000, 1'b0, pes_pkg::ST_EMITTED, 16'h0000, 48'h0},
    '{pes_pkg::OP_EMIT, 16'h0000, 16'h0000, 1'b0, pes_pkg::ST_EMITTED, 16'h0000, 48'h0},
    '{pes_pkg::OP_EMIT, 16'h0000, 16'h0000, 1'b0, pes_pkg::ST_EMITTED, 16'h0000, 48'h0},
    '{pes_pkg::OP_REGISTER, 16'h5555, 16'hAAAA, 1'b1, pes_pkg::ST_REGISTERED, 16'h0000, 48'h0},
    '{pes_pkg::OP_REGISTER, 16'hAAAA, 16'h5555, 1'b1, pes_pkg::ST_REGISTERED, 16'h0000, 48'h0},
    '{pes_pkg::OP_EMIT, 16'h0000, 16'h0000, 1'b0, pes_pkg::ST_EMITTED, 16'h0000, 48'h0}
  };

  // Closing rows, run with one free slot left. A period of zero keeps its entry due at
  // time zero forever, so it would pin every later emit and has to come last.
  stim_row_t tail_rows [5] = '{
    '{pes_pkg::OP_REGISTER, 16'h8001, 16'h0000, 1'b1, pes_pkg::ST_REGISTERED, 16'h0000, 48'h0},
    '{pes_pkg::OP_EMIT, 16'h0000, 16'h0000, 1'b1, pes_pkg::ST_EMITTED, 16'h8001, 48'h0},
    '{pes_pkg::OP_EMIT, 16'h0000, 16'h0000, 1'b1, pes_pkg::ST_EMITTED, 16'h8001, 48'h0},
    '{pes_pkg::OP_REGISTER, 16'h0001, 16'h0001, 1'b1, pes_pkg::ST_FULL, 16'h0000, 48'h0},
    '{pes_pkg::OP_EMIT, 16'h0000, 16'h0000, 1'b1, pes_pkg::ST_EMITTED, 16'h8001, 48'h0}
  };

  logic           clk_i       = 1'b0;
  logic           rst_ni      = 1'b0;
  logic           in_valid    = 1'b0;
  logic           in_ready;
  pes_pkg::in_t   in_data     = '0;
  logic           out_valid;
  logic           out_ready   = 1'b0;
  pes_pkg::out_t  out_data;

  // Shadow copy of the schedule table.
  logic [pes_pkg::TimeW-1:0]   sched_due [MaxEntries];
  logic [pes_pkg::IdW-1:0]     sched_id  [MaxEntries];
  logic [pes_pkg::PeriodW-1:0] sched_per [MaxEntries];
  int unsigned                 sched_cnt = 0;

  pes_pkg::out_t pending_results [$];
  int unsigned   mismatch_cnt   = 0;
  int unsigned   results_seen   = 0;
  int unsigned   send_gap_pct   = 0;
  int unsigned   recv_stall_pct = 0;
  int unsigned   hold_left      = 0;
  bit            hold_done      = 1'b0;
  int unsigned   quiet_cycles   = 0;

  periodic_event_scheduler_core #(
    .MAX_ENTRIES(MaxEntries)
  ) DUT (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid),
    .in_ready_o (in_ready),
    .in_data_i  (in_data),
    .out_valid_o(out_valid),
    .out_ready_i(out_ready),
    .out_data_o (out_data)
  );

  always #4 clk_i = ~clk_i;

  // True when table slot a fires ahead of slot b.
  function automatic bit fires_first(input int unsigned a, input int unsigned b);
    if (sched_due[a] != sched_due[b]) return sched_due[a] < sched_due[b];
    if (sched_id[a] != sched_id[b]) return sched_id[a] < sched_id[b];
    return sched_per[a] < sched_per[b];
  endfunction

  // Applies one item to the shadow table and returns the result it should give.
  function automatic pes_pkg::out_t schedule_step(input pes_pkg::in_t item);
    pes_pkg::out_t             res;
    int unsigned               pick;
    logic [pes_pkg::TimeW:0]   next_due;
    res = '0;
    if (item.operation == pes_pkg::OP_REGISTER) begin
      if (sched_cnt >= MaxEntries) begin
        res.status = pes_pkg::ST_FULL;
      end else begin
        sched_due[sched_cnt] = pes_pkg::TimeW'(item.period);
        sched_id[sched_cnt]  = item.entry_id;
        sched_per[sched_cnt] = item.period;
        sched_cnt++;
        res.status = pes_pkg::ST_REGISTERED;
      end
    end else if (sched_cnt == 0) begin
      res.status = pes_pkg::ST_EMPTY;
    end else begin
      pick = 0;
      for (int unsigned i = 1; i < sched_cnt; i++) begin
        if (fires_first(i, pick)) pick = i;
      end
      res.emitted_id   = sched_id[pick];
      res.emitted_time = sched_due[pick];
      next_due = {1'b0, sched_due[pick]} + (pes_pkg::TimeW + 1)'(sched_per[pick]);
      if (next_due[pes_pkg::TimeW]) begin
        res.status = pes_pkg::ST_OVERFLOW;
      end else begin
        sched_due[pick] = next_due[pes_pkg::TimeW-1:0];
        res.status = pes_pkg::ST_EMITTED;
      end
    end
    return res;
  endfunction

  // Offers one item, waits for it to be taken and records its expected result.
  task automatic offer(input pes_pkg::in_t item, input bit known, input pes_pkg::out_t typed);
    pes_pkg::out_t res;
    if ($urandom_range(99) < send_gap_pct) begin
      in_valid <= 1'b0;
      do @(posedge clk_i); while ($urandom_range(99) < send_gap_pct);
    end
    in_valid <= 1'b1;
    in_data  <= item;
    @(posedge clk_i);
    while (!in_ready) @(posedge clk_i);
    res = schedule_step(item);
    pending_results.push_back(known ? typed : res);
  endtask

  function automatic pes_pkg::in_t random_item();
    pes_pkg::in_t item;
    item.operation = ($urandom_range(7) == 0 && sched_cnt < MaxEntries - 1) ?
                     pes_pkg::OP_REGISTER : pes_pkg::OP_EMIT;
    // Small ids and periods make equal due times common, so the tie-breaks get exercised.
    case ($urandom_range(3))
      0, 1:    item.entry_id = pes_pkg::IdW'($urandom_range(7));
      default: item.entry_id = pes_pkg::IdW'($urandom());
    endcase
    case ($urandom_range(2))
      0:       item.period = pes_pkg::PeriodW'($urandom_range(8, 1));
      1:       item.period = pes_pkg::PeriodW'($urandom_range(64, 1));
      default: item.period = pes_pkg::PeriodW'($urandom_range(65535, 1));
    endcase
    return item;
  endfunction

  // Receiver: checks each result taken, then picks the next ready value.
  always @(posedge clk_i) begin
    if (rst_ni && out_valid && out_ready) begin
      results_seen++;
      if (pending_results.size() == 0) begin
        mismatch_cnt++;
        $display("%0t: unexpected result status=%0d id=%h time=%h", $realtime,
                 out_data.status, out_data.emitted_id, out_data.emitted_time);
      end else begin
        pes_pkg::out_t want;
        want = pending_results.pop_front();
        if (out_data.status != want.status) begin
          mismatch_cnt++;
          $display("%0t: status expected %0d, got %0d", $realtime, want.status,
                   out_data.status);
        end
        if (out_data.emitted_id != want.emitted_id) begin
          mismatch_cnt++;
          $display("%0t: emitted_id expected %h, got %h", $realtime, want.emitted_id,
                   out_data.emitted_id);
        end
        if (out_data.emitted_time != want.emitted_time) begin
          mismatch_cnt++;
          $display("%0t: emitted_time expected %h, got %h", $realtime,
                   want.emitted_time, out_data.emitted_time);
        end
      end
    end
    // One long hold-off lets the output register and the sequencer both fill up.
    if (hold_left > 0) begin
      hold_left--;
      out_ready <= 1'b0;
    end else if (!hold_done && results_seen >= HoldAtItem) begin
      hold_done = 1'b1;
      hold_left = HoldCycles;
      out_ready <= 1'b0;
    end else begin
      out_ready <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((in_valid && in_ready) || (out_valid && out_ready)) begin
        quiet_cycles = 0;
      end else begin
        quiet_cycles++;
      end
      if (quiet_cycles >= StallLimit) begin
        $display("Mismatches found");
        $finish;
      end
    end
  end

  initial begin
    pes_pkg::in_t item;
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (head_rows[i]) begin
      item = '{head_rows[i].op, head_rows[i].id, head_rows[i].period};
      offer(item, head_rows[i].known,
            '{head_rows[i].st, head_rows[i].oid, head_rows[i].otime});
    end

    for (int unsigned n = 0; n < RandItems; n++) begin
      case (n * 4 / RandItems)
        0:       begin send_gap_pct = 0;  recv_stall_pct = 0;  end
        1:       begin send_gap_pct = 49; recv_stall_pct = 0;  end
        2:       begin send_gap_pct = 0;  recv_stall_pct = 49; end
        default: begin send_gap_pct = 18; recv_stall_pct = 18; end
      endcase
      offer(random_item(), 1'b0, '0);
    end

    send_gap_pct   = 0;
    recv_stall_pct = 0;
    // Leave exactly one free slot for the closing rows.
    while (sched_cnt < MaxEntries - 1) begin
      item = random_item();
      item.operation = pes_pkg::OP_REGISTER;
      offer(item, 1'b0, '0);
    end
    foreach (tail_rows[i]) begin
      item = '{tail_rows[i].op, tail_rows[i].id, tail_rows[i].period};
      offer(item, tail_rows[i].known,
            '{tail_rows[i].st, tail_rows[i].oid, tail_rows[i].otime});
    end
    in_valid <= 1'b0;

    while (pending_results.size() != 0) @(posedge clk_i);
    repeat (MaxEntries + 8) @(posedge clk_i);
    if (mismatch_cnt == 0 && pending_results.size() == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule

// File: filelist.f
rtl/pes_pkg.sv
rtl/pes_table.sv
rtl/pes_cmp.sv
rtl/periodic_event_scheduler_core.sv
verif/tb.sv
